[sv/cda_pkg.sv]
// Shared types, constants and calendar tables for the date arithmetic block.
`default_nettype none

package cda_pkg;

    localparam logic [2:0] OP_LOAD = 3'd0;
    localparam logic [2:0] OP_ADD  = 3'd1;
    localparam logic [2:0] OP_NEXT = 3'd2;
    localparam logic [2:0] OP_PREV = 3'd3;
    localparam logic [2:0] OP_CMP  = 3'd4;
    localparam logic [2:0] OP_DIFF = 3'd5;

    localparam logic [1:0] CMP_EQUAL   = 2'd0;
    localparam logic [1:0] CMP_LATER   = 2'd1;
    localparam logic [1:0] CMP_EARLIER = 2'd2;

    localparam logic [13:0] YEAR_MIN   = 14'd1;
    localparam logic [13:0] YEAR_MAX   = 14'd9999;
    localparam logic [21:0] SERIAL_MAX = 22'd3652058;
    localparam logic [21:0] DAYS_400   = 22'd146097;
    localparam logic [21:0] DAYS_100   = 22'd36524;
    localparam logic [21:0] DAYS_4     = 22'd1461;
    localparam logic [21:0] DAYS_1     = 22'd365;

    localparam logic [13:0] RESET_YEAR  = 14'd2018;
    localparam logic [3:0]  RESET_MONTH = 4'd6;
    localparam logic [4:0]  RESET_DAY   = 5'd10;

    typedef struct packed {
        logic [2:0]         operation;
        logic [13:0]        year_in;
        logic [3:0]         month_in;
        logic [4:0]         day_in;
        logic signed [20:0] day_offset;
    } cda_cmd_t;

    typedef struct packed {
        logic [13:0] year_out;
        logic [3:0]  month_out;
        logic [4:0]  day_out;
        logic [1:0]  compare_code;
        logic [21:0] day_difference;
        logic        range_error;
    } cda_res_t;

    typedef struct packed {
        logic idle;
        logic done;
    } cda_stat_t;

    function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
        logic [4:0] n;
        begin
            case (m)
                4'd2:                      n = leap ? 5'd29 : 5'd28;
                4'd4, 4'd6, 4'd9, 4'd11:   n = 5'd30;
                default:                   n = 5'd31;
            endcase
            return n;
        end
    endfunction

    function automatic logic [8:0] days_before(input logic [3:0] m);
        logic [8:0] n;
        begin
            case (m)
                4'd2:    n = 9'd31;
                4'd3:    n = 9'd59;
                4'd4:    n = 9'd90;
                4'd5:    n = 9'd120;
                4'd6:    n = 9'd151;
                4'd7:    n = 9'd181;
                4'd8:    n = 9'd212;
                4'd9:    n = 9'd243;
                4'd10:   n = 9'd273;
                4'd11:   n = 9'd304;
                4'd12:   n = 9'd334;
                default: n = 9'd0;
            endcase
            return n;
        end
    endfunction

endpackage

`default_nettype wire

[sv/cda_if.sv]
// Valid/ready channel interfaces for command and result words.
`default_nettype none

interface cda_in_if;
    logic               valid;
    logic               ready;
    logic [2:0]         operation;
    logic [13:0]        year_in;
    logic [3:0]         month_in;
    logic [4:0]         day_in;
    logic signed [20:0] day_offset;

    modport source (output valid, operation, year_in, month_in, day_in, day_offset,
                    input ready);
    modport sink (input valid, operation, year_in, month_in, day_in, day_offset,
                  output ready);
endinterface

interface cda_out_if;
    logic        valid;
    logic        ready;
    logic [13:0] year_out;
    logic [3:0]  month_out;
    logic [4:0]  day_out;
    logic [1:0]  compare_code;
    logic [21:0] day_difference;
    logic        range_error;

    modport source (output valid, year_out, month_out, day_out, compare_code,
                    day_difference, range_error, input ready);
    modport sink (input valid, year_out, month_out, day_out, compare_code,
                  day_difference, range_error, output ready);
endinterface

`default_nettype wire

[sv/cda_core.sv]
// Iterative date engine: serial conversion both ways under a small sequencer.
`default_nettype none

module cda_core
    import cda_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  cda_cmd_t  cmd,
    input  logic      res_ready,
    output cda_stat_t stat,
    output cda_res_t  res
);

    typedef enum logic [12:0] {
        S_IDLE   = 13'b0000000000001,
        S_Y400   = 13'b0000000000010,
        S_Y100   = 13'b0000000000100,
        S_Y4     = 13'b0000000001000,
        S_Y1     = 13'b0000000010000,
        S_YFIN   = 13'b0000000100000,
        S_DECIDE = 13'b0000001000000,
        S_I400   = 13'b0000010000000,
        S_I100   = 13'b0000100000000,
        S_I4     = 13'b0001000000000,
        S_I1     = 13'b0010000000000,
        S_IMON   = 13'b0100000000000,
        S_FIN    = 13'b1000000000000
    } state_t;

    state_t             state_reg, state_next;
    logic [2:0]         op_reg, op_next;
    logic [13:0]        gy_reg, gy_next;
    logic [3:0]         gm_reg, gm_next;
    logic [4:0]         gd_reg, gd_next;
    logic               yerr_reg, yerr_next;
    logic signed [20:0] off_reg, off_next;
    logic               given_reg, given_next;
    logic [13:0]        rem_reg, rem_next;
    logic [21:0]        ser_reg, ser_next;
    logic [21:0]        cs_reg, cs_next;
    logic [1:0]         cnt_reg, cnt_next;
    logic [4:0]         q4_reg, q4_next;
    logic               cent_reg, cent_next;
    logic               leap_reg, leap_next;
    logic [3:0]         mon_reg, mon_next;
    logic [13:0]        cur_y_reg, cur_y_next;
    logic [3:0]         cur_m_reg, cur_m_next;
    logic [4:0]         cur_d_reg, cur_d_next;
    logic [1:0]         cmp_reg, cmp_next;
    logic [21:0]        diff_reg, diff_next;
    logic               err_reg, err_next;

    logic [13:0]        ry;
    logic [3:0]         rm;
    logic [4:0]         rd;
    logic [4:0]         dim;
    logic [4:0]         dc;
    logic [13:0]        cy;
    logic [3:0]         cm;
    logic               cyerr;
    logic signed [23:0] tsum;

    assign ry  = given_reg ? gy_reg : cur_y_reg;
    assign rm  = given_reg ? gm_reg : cur_m_reg;
    assign rd  = given_reg ? gd_reg : cur_d_reg;
    assign dim = month_days((state_reg == S_IMON) ? mon_reg : rm, leap_reg);
    assign dc  = (rd == 5'd0) ? 5'd1 : ((rd > dim) ? dim : rd);

    assign cyerr = (cmd.year_in == 14'd0) || (cmd.year_in > YEAR_MAX);
    assign cy    = (cmd.year_in == 14'd0) ? YEAR_MIN :
                   ((cmd.year_in > YEAR_MAX) ? YEAR_MAX : cmd.year_in);
    assign cm    = (cmd.month_in == 4'd0) ? 4'd1 :
                   ((cmd.month_in > 4'd12) ? 4'd12 : cmd.month_in);

    assign tsum = $signed({2'b00, ser_reg}) + $signed({{3{off_reg[20]}}, off_reg});

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        gy_next    = gy_reg;
        gm_next    = gm_reg;
        gd_next    = gd_reg;
        yerr_next  = yerr_reg;
        off_next   = off_reg;
        given_next = given_reg;
        rem_next   = rem_reg;
        ser_next   = ser_reg;
        cs_next    = cs_reg;
        cnt_next   = cnt_reg;
        q4_next    = q4_reg;
        cent_next  = cent_reg;
        leap_next  = leap_reg;
        mon_next   = mon_reg;
        cur_y_next = cur_y_reg;
        cur_m_next = cur_m_reg;
        cur_d_next = cur_d_reg;
        cmp_next   = cmp_reg;
        diff_next  = diff_reg;
        err_next   = err_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next   = cmd.operation;
                    gy_next   = cy;
                    gm_next   = cm;
                    gd_next   = cmd.day_in;
                    yerr_next = cyerr;
                    cmp_next  = CMP_EQUAL;
                    diff_next = 22'd0;
                    err_next  = 1'b0;
                    ser_next  = 22'd0;
                    cnt_next  = 2'd0;
                    case (cmd.operation)
                        OP_NEXT: off_next = 21'sd1;
                        OP_PREV: off_next = -21'sd1;
                        default: off_next = cmd.day_offset;
                    endcase
                    case (cmd.operation)
                        OP_LOAD:
                        begin
                            given_next = 1'b1;
                            rem_next   = cy - 14'd1;
                            state_next = S_Y400;
                        end
                        OP_ADD, OP_NEXT, OP_PREV, OP_CMP, OP_DIFF:
                        begin
                            given_next = 1'b0;
                            rem_next   = cur_y_reg - 14'd1;
                            state_next = S_Y400;
                        end
                        default:
                        begin
                            state_next = S_FIN;
                        end
                    endcase
                end
            end
            S_Y400:
            begin
                if (rem_reg >= 14'd400)
                begin
                    rem_next = rem_reg - 14'd400;
                    ser_next = ser_reg + DAYS_400;
                end
                else
                begin
                    cnt_next   = 2'd0;
                    state_next = S_Y100;
                end
            end
            S_Y100:
            begin
                if (rem_reg >= 14'd100 && cnt_reg != 2'd3)
                begin
                    rem_next = rem_reg - 14'd100;
                    ser_next = ser_reg + DAYS_100;
                    cnt_next = cnt_reg + 2'd1;
                end
                else
                begin
                    cent_next  = (rem_reg != 14'd99) || (cnt_reg == 2'd3);
                    state_next = S_Y4;
                end
            end
            S_Y4:
            begin
                if (rem_reg >= 14'd4)
                begin
                    rem_next = rem_reg - 14'd4;
                    ser_next = ser_reg + DAYS_4;
                end
                else
                begin
                    state_next = S_Y1;
                end
            end
            S_Y1:
            begin
                if (rem_reg != 14'd0)
                begin
                    rem_next = rem_reg - 14'd1;
                    ser_next = ser_reg + DAYS_1;
                end
                else
                begin
                    leap_next  = (ry[1:0] == 2'b00) && cent_reg;
                    state_next = S_YFIN;
                end
            end
            S_YFIN:
            begin
                ser_next = ser_reg + {13'd0, days_before(rm)}
                         + {21'd0, (rm > 4'd2) && leap_reg}
                         + {17'd0, dc - 5'd1};
                if (given_reg)
                begin
                    gd_next = dc;
                end
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                case (op_reg)
                    OP_LOAD:
                    begin
                        cur_y_next = gy_reg;
                        cur_m_next = gm_reg;
                        cur_d_next = gd_reg;
                        err_next   = yerr_reg;
                        state_next = S_FIN;
                    end
                    OP_CMP, OP_DIFF:
                    begin
                        if (!given_reg)
                        begin
                            cs_next    = ser_reg;
                            given_next = 1'b1;
                            rem_next   = gy_reg - 14'd1;
                            ser_next   = 22'd0;
                            state_next = S_Y400;
                        end
                        else
                        begin
                            if (op_reg == OP_CMP)
                            begin
                                cmp_next = (cs_reg > ser_reg) ? CMP_LATER :
                                           ((cs_reg < ser_reg) ? CMP_EARLIER : CMP_EQUAL);
                            end
                            else
                            begin
                                diff_next = (cs_reg > ser_reg) ? cs_reg - ser_reg
                                                               : ser_reg - cs_reg;
                            end
                            state_next = S_FIN;
                        end
                    end
                    default:
                    begin
                        if (tsum[23])
                        begin
                            ser_next = 22'd0;
                            err_next = 1'b1;
                        end
                        else if (tsum > $signed({2'b00, SERIAL_MAX}))
                        begin
                            ser_next = SERIAL_MAX;
                            err_next = 1'b1;
                        end
                        else
                        begin
                            ser_next = tsum[21:0];
                        end
                        rem_next   = YEAR_MIN;
                        state_next = S_I400;
                    end
                endcase
            end
            S_I400:
            begin
                if (ser_reg >= DAYS_400)
                begin
                    ser_next = ser_reg - DAYS_400;
                    rem_next = rem_reg + 14'd400;
                end
                else
                begin
                    cnt_next   = 2'd0;
                    state_next = S_I100;
                end
            end
            S_I100:
            begin
                if (ser_reg >= DAYS_100 && cnt_reg != 2'd3)
                begin
                    ser_next = ser_reg - DAYS_100;
                    rem_next = rem_reg + 14'd100;
                    cnt_next = cnt_reg + 2'd1;
                end
                else
                begin
                    cent_next  = (cnt_reg == 2'd3);
                    cnt_next   = 2'd0;
                    q4_next    = 5'd0;
                    state_next = S_I4;
                end
            end
            S_I4:
            begin
                if (ser_reg >= DAYS_4)
                begin
                    ser_next = ser_reg - DAYS_4;
                    rem_next = rem_reg + 14'd4;
                    q4_next  = q4_reg + 5'd1;
                end
                else
                begin
                    state_next = S_I1;
                end
            end
            S_I1:
            begin
                if (ser_reg >= DAYS_1 && cnt_reg != 2'd3)
                begin
                    ser_next = ser_reg - DAYS_1;
                    rem_next = rem_reg + 14'd1;
                    cnt_next = cnt_reg + 2'd1;
                end
                else
                begin
                    leap_next  = (cnt_reg == 2'd3) && ((q4_reg != 5'd24) || cent_reg);
                    mon_next   = 4'd1;
                    state_next = S_IMON;
                end
            end
            S_IMON:
            begin
                if (mon_reg != 4'd12 && ser_reg >= {17'd0, dim})
                begin
                    ser_next = ser_reg - {17'd0, dim};
                    mon_next = mon_reg + 4'd1;
                end
                else
                begin
                    cur_y_next = rem_reg;
                    cur_m_next = mon_reg;
                    cur_d_next = ser_reg[4:0] + 5'd1;
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cur_y_reg <= RESET_YEAR;
            cur_m_reg <= RESET_MONTH;
            cur_d_reg <= RESET_DAY;
        end
        else
        begin
            state_reg <= state_next;
            cur_y_reg <= cur_y_next;
            cur_m_reg <= cur_m_next;
            cur_d_reg <= cur_d_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        gy_reg    <= gy_next;
        gm_reg    <= gm_next;
        gd_reg    <= gd_next;
        yerr_reg  <= yerr_next;
        off_reg   <= off_next;
        given_reg <= given_next;
        rem_reg   <= rem_next;
        ser_reg   <= ser_next;
        cs_reg    <= cs_next;
        cnt_reg   <= cnt_next;
        q4_reg    <= q4_next;
        cent_reg  <= cent_next;
        leap_reg  <= leap_next;
        mon_reg   <= mon_next;
        cmp_reg   <= cmp_next;
        diff_reg  <= diff_next;
        err_reg   <= err_next;
    end

    assign stat.idle = (state_reg == S_IDLE);
    assign stat.done = (state_reg == S_FIN) && res_ready;

    assign res.year_out       = cur_y_reg;
    assign res.month_out      = cur_m_reg;
    assign res.day_out        = cur_d_reg;
    assign res.compare_code   = cmp_reg;
    assign res.day_difference = diff_reg;
    assign res.range_error    = err_reg;

endmodule

`default_nettype wire

[sv/calendar_date_arithmetic.sv]
// Top level: Gregorian date arithmetic with command and result channels.
// Unused codes go straight to the result; load walks one date to a day serial, compare or
// difference walks two, and add or a day step walks the date to a serial and back again.
// Throughput: one word at a time; the next word is taken once the engine is back in idle.
// Cost is set by the shared subtract/compare step that walks 400-, 100-, 4- and 1-year spans.
// Reset (asynchronous, active low) sets the date to 2018-06-10 and clears the result valid flag.
`default_nettype none

module calendar_date_arithmetic
    import cda_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    cda_in_if.sink      in_ch,
    cda_out_if.source   out_ch
);

    cda_cmd_t  cmd;
    cda_res_t  res;
    cda_stat_t stat;
    logic      start;
    logic      res_ready;
    logic      out_valid_reg;
    cda_res_t  out_reg;

    assign cmd.operation  = in_ch.operation;
    assign cmd.year_in    = in_ch.year_in;
    assign cmd.month_in   = in_ch.month_in;
    assign cmd.day_in     = in_ch.day_in;
    assign cmd.day_offset = in_ch.day_offset;

    assign in_ch.ready = stat.idle;
    assign start       = in_ch.valid && stat.idle;
    assign res_ready   = !out_valid_reg || out_ch.ready;

    cda_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .cmd       (cmd),
        .res_ready (res_ready),
        .stat      (stat),
        .res       (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (stat.done)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stat.done)
        begin
            out_reg <= res;
        end
    end

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.year_out       = out_reg.year_out;
    assign out_ch.month_out      = out_reg.month_out;
    assign out_ch.day_out        = out_reg.day_out;
    assign out_ch.compare_code   = out_reg.compare_code;
    assign out_ch.day_difference = out_reg.day_difference;
    assign out_ch.range_error    = out_reg.range_error;

    a_done_gives_word: assert property (@(posedge clk) disable iff (!rst_n)
        stat.done |=> out_ch.valid)
        else $error("finished word not presented");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
        else $error("engine took a word while busy");

    a_compare_code_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> (out_ch.compare_code != 2'd3))
        else $error("illegal compare code");

    a_month_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> (out_ch.month_out >= 4'd1 && out_ch.month_out <= 4'd12))
        else $error("month out of range");

endmodule

`default_nettype wire

[tb/sv/tb_calendar_date_arithmetic.sv]
// Self-checking testbench for the Gregorian date arithmetic block.
`timescale 1ns / 100ps

module tb_calendar_date_arithmetic
    import cda_pkg::*;
;

    logic clk;
    logic rst_n;

    cda_in_if  in_ch ();
    cda_out_if out_ch ();

    calendar_date_arithmetic u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    cda_cmd_t pending_cmds[$];
    cda_res_t expected_dates[$];

    int unsigned date_y;
    int unsigned date_m;
    int unsigned date_d;

    int send_idle_pct;
    int recv_idle_pct;
    int hold_off_cycles;
    int mismatches;
    int cycle_count;
    bit stimulus_done;

    function automatic bit leap_year(int unsigned y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic int unsigned month_length(int unsigned y, int unsigned m);
        int unsigned lens[12];
        lens = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
        if (m == 2 && leap_year(y))
            return 29;
        return lens[m - 1];
    endfunction

    function automatic longint day_serial(int unsigned y, int unsigned m, int unsigned d);
        int unsigned days_ahead[12];
        longint p;
        longint s;
        days_ahead = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};
        p = y - 1;
        s = p * 365 + p / 4 - p / 100 + p / 400 + days_ahead[m - 1] + d - 1;
        if (m > 2 && leap_year(y))
            s++;
        return s;
    endfunction

    function automatic bit clamp_date(inout int unsigned y, inout int unsigned m,
                                      inout int unsigned d);
        bit flag;
        flag = 1'b0;
        if (y < 1) begin y = 1; flag = 1'b1; end
        if (y > 9999) begin y = 9999; flag = 1'b1; end
        if (m < 1) m = 1;
        if (m > 12) m = 12;
        if (d < 1) d = 1;
        if (d > month_length(y, m)) d = month_length(y, m);
        return flag;
    endfunction

    function automatic bit set_from_serial(longint s);
        bit flag;
        longint n;
        int unsigned q400, q100, q4, q1, m;
        flag = 1'b0;
        if (s < 0) begin s = 0; flag = 1'b1; end
        if (s > 3652058) begin s = 3652058; flag = 1'b1; end
        n = s;
        q400 = n / 146097; n = n % 146097;
        q100 = n / 36524; if (q100 > 3) q100 = 3; n = n - q100 * 36524;
        q4 = n / 1461; n = n % 1461;
        q1 = n / 365; if (q1 > 3) q1 = 3; n = n - q1 * 365;
        date_y = q400 * 400 + q100 * 100 + q4 * 4 + q1 + 1;
        m = 1;
        while (m < 12 && n >= month_length(date_y, m))
        begin
            n = n - month_length(date_y, m);
            m++;
        end
        date_m = m;
        date_d = 32'(n + 1);
        return flag;
    endfunction

    function automatic cda_res_t advance_date(cda_cmd_t c);
        cda_res_t r;
        int unsigned gy, gm, gd;
        longint cs, gs;
        r = '0;
        gy = c.year_in;
        gm = c.month_in;
        gd = c.day_in;
        cs = day_serial(date_y, date_m, date_d);
        case (c.operation)
            OP_LOAD:
            begin
                r.range_error = clamp_date(gy, gm, gd);
                date_y = gy; date_m = gm; date_d = gd;
            end
            OP_ADD:  r.range_error = set_from_serial(cs + longint'(c.day_offset));
            OP_NEXT: r.range_error = set_from_serial(cs + 1);
            OP_PREV: r.range_error = set_from_serial(cs - 1);
            OP_CMP, OP_DIFF:
            begin
                void'(clamp_date(gy, gm, gd));
                gs = day_serial(gy, gm, gd);
                if (c.operation == OP_CMP)
                    r.compare_code = (cs > gs) ? CMP_LATER : (cs < gs) ? CMP_EARLIER : CMP_EQUAL;
                else
                    r.day_difference = 22'((cs > gs) ? cs - gs : gs - cs);
            end
            default: ;
        endcase
        r.year_out = 14'(date_y);
        r.month_out = 4'(date_m);
        r.day_out = 5'(date_d);
        return r;
    endfunction

    function automatic cda_cmd_t make_cmd(logic [2:0] op, int unsigned y, int unsigned m,
                                          int unsigned d, int off);
        cda_cmd_t c;
        c.operation = op;
        c.year_in = 14'(y);
        c.month_in = 4'(m);
        c.day_in = 5'(d);
        c.day_offset = 21'(off);
        return c;
    endfunction

    function automatic cda_cmd_t random_cmd();
        cda_cmd_t c;
        int unsigned pick;
        c.operation = 3'($urandom_range(0, 5));
        if ($urandom_range(0, 15) == 0)
            c.operation = 3'($urandom_range(6, 7));
        c.year_in = 14'(($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(1, 9999));
        c.month_in = 4'(($urandom_range(0, 5) == 0) ? $urandom : $urandom_range(1, 12));
        c.day_in = 5'($urandom);
        pick = $urandom_range(0, 3);
        if (pick == 0)
            c.day_offset = 21'($urandom);
        else if (pick == 1)
            c.day_offset = 21'($signed($urandom_range(0, 800)) - 400);
        else
            c.day_offset = 21'($signed($urandom_range(0, 80000)) - 40000);
        return c;
    endfunction

    // Driver: offer the queued words, idling at random.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
            in_ch.operation <= '0;
            in_ch.year_in <= '0;
            in_ch.month_in <= '0;
            in_ch.day_in <= '0;
            in_ch.day_offset <= '0;
        end
        else if (!in_ch.valid || in_ch.ready)
        begin
            if (pending_cmds.size() > 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                cda_cmd_t c;
                c = pending_cmds.pop_front();
                in_ch.valid <= 1'b1;
                in_ch.operation <= c.operation;
                in_ch.year_in <= c.year_in;
                in_ch.month_in <= c.month_in;
                in_ch.day_in <= c.day_in;
                in_ch.day_offset <= c.day_offset;
            end
            else
                in_ch.valid <= 1'b0;
        end
    end

    // Predict on acceptance of each command word.
    always @(posedge clk)
    begin
        if (rst_n && in_ch.valid && in_ch.ready)
            expected_dates.push_back(advance_date(make_cmd(in_ch.operation, in_ch.year_in,
                in_ch.month_in, in_ch.day_in, in_ch.day_offset)));
    end

    // Monitor: compare each accepted result word with the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                cda_res_t got, want;
                got.year_out = out_ch.year_out;
                got.month_out = out_ch.month_out;
                got.day_out = out_ch.day_out;
                got.compare_code = out_ch.compare_code;
                got.day_difference = out_ch.day_difference;
                got.range_error = out_ch.range_error;
                if (expected_dates.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result word %p", got);
                end
                else
                begin
                    want = expected_dates.pop_front();
                    if (got !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected %p, got %p", want, got);
                    end
                end
            end
            if (hold_off_cycles > 0)
            begin
                out_ch.ready <= 1'b0;
                hold_off_cycles <= hold_off_cycles - 1;
            end
            else
                out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 2000000)
        begin
            $display("timeout");
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic drain_words();
        wait (pending_cmds.size() == 0);
        @(posedge clk);
        while (in_ch.valid || expected_dates.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    task automatic queue_random(int count);
        for (int i = 0; i < count; i++)
            pending_cmds.push_back(random_cmd());
    endtask

    initial
    begin
        cycle_count = 0;
        mismatches = 0;
        hold_off_cycles = 0;
        stimulus_done = 1'b0;
        send_idle_pct = 23;
        recv_idle_pct = 76;
        date_y = RESET_YEAR;
        date_m = RESET_MONTH;
        date_d = RESET_DAY;
        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        pending_cmds.push_back(make_cmd(OP_CMP, 2018, 6, 10, 0));
        pending_cmds.push_back(make_cmd(OP_LOAD, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(OP_PREV, 1, 1, 1, 0));
        pending_cmds.push_back(make_cmd(OP_LOAD, 16383, 15, 31, 0));
        pending_cmds.push_back(make_cmd(OP_NEXT, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(OP_DIFF, 1, 1, 1, 0));
        pending_cmds.push_back(make_cmd(OP_DIFF, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(OP_LOAD, 2000, 2, 31, 0));
        pending_cmds.push_back(make_cmd(OP_NEXT, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(OP_LOAD, 1900, 2, 29, 0));
        pending_cmds.push_back(make_cmd(OP_NEXT, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(OP_LOAD, 2024, 4, 31, 0));
        pending_cmds.push_back(make_cmd(OP_ADD, 31, 31, 31, 1048575));
        pending_cmds.push_back(make_cmd(OP_ADD, 0, 0, 0, -1048576));
        pending_cmds.push_back(make_cmd(OP_ADD, 0, 0, 0, -1048576));
        pending_cmds.push_back(make_cmd(OP_ADD, 0, 0, 0, -1048576));
        pending_cmds.push_back(make_cmd(OP_ADD, 0, 0, 0, -1048576));
        pending_cmds.push_back(make_cmd(OP_LOAD, 9999, 12, 31, 0));
        pending_cmds.push_back(make_cmd(OP_ADD, 0, 0, 0, 1));
        pending_cmds.push_back(make_cmd(OP_CMP, 9999, 12, 30, 0));
        pending_cmds.push_back(make_cmd(OP_CMP, 10000, 12, 31, 0));
        pending_cmds.push_back(make_cmd(OP_CMP, 16383, 15, 0, 0));
        pending_cmds.push_back(make_cmd(6, 1234, 5, 6, 7));
        pending_cmds.push_back(make_cmd(7, 0, 0, 0, -1));
        queue_random(40);
        wait (pending_cmds.size() == 0);
        hold_off_cycles = 3000;
        queue_random(5);
        drain_words();

        send_idle_pct = 76;
        recv_idle_pct = 23;
        queue_random(35);
        drain_words();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_random(35);
        drain_words();

        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
